FILE: rtl/core/hcbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
package hcbd_pkg;

  localparam int unsigned DefLineCapacity = 128;
  localparam int unsigned DefSizeBits     = 32;

  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrLowX  = 8'h78;
  localparam logic [7:0] ChrUpX   = 8'h58;

  localparam logic KindByte  = 1'b0;
  localparam logic KindClose = 1'b1;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } hcbd_status_t;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_PAYLOAD  = 3'd1,
    PH_WANT_CR  = 3'd2,
    PH_WANT_LF  = 3'd3,
    PH_TRAILER  = 3'd4,
    PH_DONE     = 3'd5,
    PH_ERROR    = 3'd6
  } hcbd_phase_t;

  typedef enum logic [2:0] {
    SC_LEAD   = 3'd0,
    SC_SIGN   = 3'd1,
    SC_ZERO   = 3'd2,
    SC_PREFIX = 3'd3,
    SC_DIGITS = 3'd4,
    SC_END    = 3'd5,
    SC_MINUS  = 3'd6
  } hcbd_scan_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hcbd_in_t;

  typedef struct packed {
    logic [7:0]   payload_byte;
    logic         payload_valid;
    hcbd_status_t status;
  } hcbd_out_t;

  // Control part of the decoder state; the counters travel separately.
  typedef struct packed {
    hcbd_phase_t phase;
    hcbd_scan_t  scan;
    logic        digits_found;
    logic        last_was_cr;
  } hcbd_ctrl_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      v = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {8'h20, [8'h09:8'h0D]});
  endfunction

endpackage

FILE: rtl/core/hcbd_step.sv
// Next-state and result logic for one stream word of the chunked body decoder.
module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = DefLineCapacity,
  parameter int unsigned SIZE_BITS     = DefSizeBits,
  localparam int unsigned LcW          = $clog2(LINE_CAPACITY)
) (
  input  hcbd_in_t               word,
  input  hcbd_ctrl_t             ctrl,
  input  logic [SIZE_BITS-1:0]   chunk,
  input  logic [LcW-1:0]         line_count,
  output hcbd_ctrl_t             ctrl_next,
  output logic [SIZE_BITS-1:0]   chunk_next,
  output logic [LcW-1:0]         line_next,
  output hcbd_out_t              result
);

  localparam logic [LcW-1:0] LineLimit = LcW'(LINE_CAPACITY - 2);

  logic [7:0]           b;
  logic                 b_hex;
  logic [SIZE_BITS-1:0] chunk_digit;
  logic [SIZE_BITS-1:0] chunk_dec;
  hcbd_scan_t           scan_next;
  logic                 add_en;
  logic                 take_num;

  assign b     = word.data_byte;
  assign b_hex = is_hex(b);

  // Shifting in a digit saturates once any of the top four bits is set.
  assign chunk_digit = (|chunk[SIZE_BITS-1 -: 4]) ? {SIZE_BITS{1'b1}}
                                                   : {chunk[SIZE_BITS-5:0], hex_value(b)};
  assign chunk_dec   = chunk - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // Size line number scanner.
  always_comb begin
    scan_next = ctrl.scan;
    add_en    = 1'b0;
    take_num  = 1'b0;
    case (ctrl.scan)
      SC_LEAD: begin
        if (is_space(b)) begin
          scan_next = SC_LEAD;
        end else if (b == ChrPlus) begin
          scan_next = SC_SIGN;
        end else if (b == ChrMinus) begin
          scan_next = SC_MINUS;
        end else begin
          take_num = 1'b1;
        end
      end
      SC_SIGN: take_num = 1'b1;
      SC_ZERO: begin
        if (b == ChrLowX || b == ChrUpX) begin
          scan_next = SC_PREFIX;
        end else if (b_hex) begin
          add_en    = 1'b1;
          scan_next = SC_DIGITS;
        end else begin
          scan_next = SC_END;
        end
      end
      SC_PREFIX, SC_DIGITS: begin
        if (b_hex) begin
          add_en    = 1'b1;
          scan_next = SC_DIGITS;
        end else begin
          scan_next = SC_END;
        end
      end
      default: scan_next = ctrl.scan;
    endcase
    if (take_num) begin
      if (b == ChrZero) begin
        add_en    = 1'b1;
        scan_next = SC_ZERO;
      end else if (b_hex) begin
        add_en    = 1'b1;
        scan_next = SC_DIGITS;
      end else begin
        scan_next = SC_END;
      end
    end
  end

  always_comb begin
    ctrl_next  = ctrl;
    chunk_next = chunk;
    line_next  = line_count;
    result     = '0;
    if (word.kind == KindClose) begin
      if (ctrl.phase != PH_DONE) begin
        ctrl_next.phase = PH_ERROR;
      end
    end else begin
      case (ctrl.phase)
        PH_SIZE, PH_TRAILER: begin
          if (b == ChrLf) begin
            if (ctrl.phase == PH_SIZE) begin
              if (ctrl.scan == SC_MINUS || !ctrl.digits_found) begin
                ctrl_next.phase = PH_ERROR;
              end else if (chunk == '0) begin
                ctrl_next.phase = PH_TRAILER;
              end else begin
                ctrl_next.phase = PH_PAYLOAD;
              end
            end else if (line_count == '0 ||
                         (line_count == LcW'(1) && ctrl.last_was_cr)) begin
              ctrl_next.phase = PH_DONE;
            end
            line_next              = '0;
            ctrl_next.scan         = SC_LEAD;
            ctrl_next.digits_found = 1'b0;
            ctrl_next.last_was_cr  = 1'b0;
          end else if (line_count >= LineLimit) begin
            ctrl_next.phase = PH_ERROR;
          end else begin
            line_next             = line_count + LcW'(1);
            ctrl_next.last_was_cr = (b == ChrCr);
            if (ctrl.phase == PH_SIZE) begin
              ctrl_next.scan = scan_next;
              if (add_en) begin
                chunk_next             = chunk_digit;
                ctrl_next.digits_found = 1'b1;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          result.payload_byte  = b;
          result.payload_valid = 1'b1;
          chunk_next           = chunk_dec;
          if (chunk_dec == '0) begin
            ctrl_next.phase = PH_WANT_CR;
          end
        end
        PH_WANT_CR: ctrl_next.phase = (b == ChrCr) ? PH_WANT_LF : PH_ERROR;
        PH_WANT_LF: begin
          if (b == ChrLf) begin
            ctrl_next.phase        = PH_SIZE;
            chunk_next             = '0;
            line_next              = '0;
            ctrl_next.scan         = SC_LEAD;
            ctrl_next.digits_found = 1'b0;
            ctrl_next.last_was_cr  = 1'b0;
          end else begin
            ctrl_next.phase = PH_ERROR;
          end
        end
        PH_DONE: ctrl_next.phase = PH_DONE;
        default: ctrl_next.phase = PH_ERROR;
      endcase
    end

    case (ctrl_next.phase)
      PH_DONE:  result.status = ST_DONE;
      PH_ERROR: result.status = ST_ERROR;
      default:  result.status = ST_BUSY;
    endcase
  end

endmodule

FILE: rtl/core/http_chunked_body_decoder.sv
// Decoder state updates as each word leaves the input register and its result enters out_data.
// Throughput: one word per cycle, unless out_ready low holds a result in the output register.
// The output register lets a new word in while a finished result still waits for out_ready.
// Reset (rst, synchronous): both registers empty, decoder back to reading a size line.
// Top level of the HTTP chunked body decoder.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = DefLineCapacity,
  parameter int unsigned SIZE_BITS     = DefSizeBits
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hcbd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hcbd_out_t out_data
);

  localparam int unsigned LcW = $clog2(LINE_CAPACITY);

  logic                 s1_valid;
  hcbd_in_t             s1_data;
  logic                 advance;

  hcbd_ctrl_t           ctrl;
  hcbd_ctrl_t           ctrl_next;
  logic [SIZE_BITS-1:0] chunk;
  logic [SIZE_BITS-1:0] chunk_next;
  logic [LcW-1:0]       line_count;
  logic [LcW-1:0]       line_next;
  hcbd_out_t            result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  hcbd_step #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .SIZE_BITS    (SIZE_BITS)
  ) u_step (
    .word      (s1_data),
    .ctrl      (ctrl),
    .chunk     (chunk),
    .line_count(line_count),
    .ctrl_next (ctrl_next),
    .chunk_next(chunk_next),
    .line_next (line_next),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      ctrl       <= '{phase: PH_SIZE, scan: SC_LEAD, digits_found: 1'b0, last_was_cr: 1'b0};
      chunk      <= '0;
      line_count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        ctrl       <= ctrl_next;
        chunk      <= chunk_next;
        line_count <= line_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/core/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
module hcbd_checker
  import hcbd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input hcbd_out_t out_data
);

  logic seen_error;
  logic seen_done;

  // Remember whether an error or completion word has already left the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_error <= 1'b0;
      seen_done  <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_data.status == ST_ERROR) begin
        seen_error <= 1'b1;
      end
      if (out_data.status == ST_DONE) begin
        seen_done <= 1'b1;
      end
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_error) |-> out_data.status == ST_ERROR)
    else $error("status left error after an error word");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_done) |-> out_data.status == ST_DONE)
    else $error("status left complete after a completion word");

  a_payload_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.payload_valid) |-> out_data.status == ST_BUSY)
    else $error("payload word with a final status");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.payload_valid) |-> out_data.payload_byte == 8'd0)
    else $error("payload byte nonzero on a non-payload word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed or dropped");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
